// ===== hw/rtl/nsc_pkg.sv =====
// Shared constants, types and helpers for the NMEA sentence checker.
package nsc_pkg;

  localparam int BUF_DEPTH_DEF = 128;
  localparam int SUM_START_DEF = 1;
  localparam int TAIL_LEN_DEF  = 5;
  localparam int HEX_POS_DEF   = 4;

  localparam int CNT_W     = 8;
  localparam int TAG_COUNT = 6;
  localparam int TYPE_W    = 3;

  localparam logic [7:0]        LINE_FEED = 8'h0A;
  localparam logic [TYPE_W-1:0] NO_TAG    = 3'd6;

  localparam logic [23:0] TAG_CODES [TAG_COUNT] = '{
    24'h524D43,  // RMC
    24'h565447,  // VTG
    24'h474741,  // GGA
    24'h475341,  // GSA
    24'h475356,  // GSV
    24'h474C4C   // GLL
  };

  typedef struct packed {
    logic                 fire;
    logic                 overflow;
    logic [TAG_COUNT-1:0] seen;
  } snap_ctrl_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/nsc_track.sv =====
// Input register and per-sentence state: count, XOR, tail bytes, tag window.
module nsc_track
  import nsc_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF,
  parameter int SUM_START = SUM_START_DEF,
  parameter int TAIL_LEN  = TAIL_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          data_valid,
  output logic                          data_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          slot_busy,
  output snap_ctrl_t                    snap_ctrl,
  output logic [CNT_W-1:0]              snap_len,
  output logic [7:0]                    snap_xor,
  output logic [TAIL_LEN-1:0][7:0]      snap_tail
);

  logic                     byte_valid;
  logic [7:0]               byte_reg;
  logic [CNT_W-1:0]         byte_count;
  logic [7:0]               running_xor;
  logic [TAIL_LEN-1:0][7:0] tail_history;
  logic [23:0]              tag_window;
  logic [TAG_COUNT-1:0]     tag_seen;
  logic                     overflow_seen;

  logic                     store;
  logic                     is_lf;
  logic                     hold;
  logic                     advance;
  logic [CNT_W-1:0]         byte_count_next;
  logic [7:0]               running_xor_next;
  logic [TAIL_LEN-1:0][7:0] tail_history_next;
  logic [23:0]              tag_window_next;
  logic [TAG_COUNT-1:0]     tag_seen_next;
  logic                     overflow_seen_next;
  logic [23:0]              window_shift;
  logic [TAG_COUNT-1:0]     tag_match;

  assign is_lf   = (byte_reg == LINE_FEED);
  assign hold    = byte_valid && is_lf && slot_busy;
  assign advance = byte_valid && !hold;
  assign store   = (byte_count < CNT_W'(BUF_DEPTH));
  assign data_stall = hold;

  assign window_shift = {tag_window[15:0], byte_reg};

  always_comb begin
    for (int i = 0; i < TAG_COUNT; i++) begin
      tag_match[i] = (window_shift == TAG_CODES[i]);
    end
  end

  always_comb begin
    byte_count_next    = byte_count;
    running_xor_next   = running_xor;
    tail_history_next  = tail_history;
    tag_window_next    = tag_window;
    tag_seen_next      = tag_seen;
    overflow_seen_next = overflow_seen;
    if (store) begin
      byte_count_next = byte_count + CNT_W'(1);
      if (byte_count >= CNT_W'(SUM_START)) begin
        running_xor_next = running_xor ^ byte_reg;
      end
      for (int k = TAIL_LEN - 1; k > 0; k--) begin
        tail_history_next[k] = tail_history[k-1];
      end
      tail_history_next[0] = byte_reg;
      tag_window_next = window_shift;
      tag_seen_next   = tag_seen | tag_match;
    end else begin
      overflow_seen_next = 1'b1;
    end
  end

  assign snap_ctrl.fire     = advance && is_lf;
  assign snap_ctrl.overflow = overflow_seen_next;
  assign snap_ctrl.seen     = tag_seen_next;
  assign snap_len           = byte_count_next;
  assign snap_xor           = running_xor_next;
  assign snap_tail          = tail_history_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!hold) begin
      byte_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !hold) begin
      byte_reg <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && is_lf)) begin
      byte_count    <= '0;
      running_xor   <= '0;
      tail_history  <= '0;
      tag_window    <= '0;
      tag_seen      <= '0;
      overflow_seen <= 1'b0;
    end else if (advance) begin
      byte_count    <= byte_count_next;
      running_xor   <= running_xor_next;
      tail_history  <= tail_history_next;
      tag_window    <= tag_window_next;
      tag_seen      <= tag_seen_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// ===== hw/rtl/nsc_result.sv =====
// Result evaluation, type enable register and the output word register.
module nsc_result
  import nsc_pkg::*;
#(
  parameter int SUM_START = SUM_START_DEF,
  parameter int TAIL_LEN  = TAIL_LEN_DEF,
  parameter int HEX_POS   = HEX_POS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [TAG_COUNT-1:0]     cfg_wdata,
  input  snap_ctrl_t               snap_ctrl,
  input  logic [CNT_W-1:0]         snap_len,
  input  logic [7:0]               snap_xor,
  input  logic [TAIL_LEN-1:0][7:0] snap_tail,
  output logic                     slot_busy,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     checksum_ok,
  output logic [TYPE_W-1:0]        sentence_type,
  output logic                     accepted,
  output logic [7:0]               computed_sum,
  output logic [7:0]               received_sum,
  output logic [CNT_W-1:0]         sentence_length,
  output logic                     format_error
);

  logic [TAG_COUNT-1:0] type_enable_mask;

  logic [7:0]           calc;
  logic [7:0]           recv;
  logic [4:0]           d1;
  logic [4:0]           d2;
  logic                 c1_ok;
  logic                 c2_ok;
  logic [TYPE_W-1:0]    type_code;
  logic [TAG_COUNT-1:0] lowest;
  logic                 ok;
  logic                 ferr;
  logic                 acc;

  // strip the checksum field and everything after it from the XOR
  always_comb begin
    calc = snap_xor;
    for (int k = 0; k < TAIL_LEN; k++) begin
      if (k < HEX_POS && {1'b0, snap_len} >= (CNT_W + 1)'(k + 1 + SUM_START)) begin
        calc = calc ^ snap_tail[k];
      end
    end
  end

  assign c1_ok = (snap_len >= CNT_W'(HEX_POS));
  assign c2_ok = (snap_len >= CNT_W'(HEX_POS - 1));
  assign d1    = c1_ok ? hex_digit(snap_tail[HEX_POS-1]) : 5'd0;
  assign d2    = c2_ok ? hex_digit(snap_tail[HEX_POS-2]) : 5'd0;

  always_comb begin
    if (!d1[4]) begin
      recv = 8'd0;
    end else if (!d2[4]) begin
      recv = {4'd0, d1[3:0]};
    end else begin
      recv = {d1[3:0], d2[3:0]};
    end
  end

  always_comb begin
    type_code = NO_TAG;
    for (int k = TAG_COUNT - 1; k >= 0; k--) begin
      if (snap_ctrl.seen[k]) begin
        type_code = TYPE_W'(k);
      end
    end
  end

  assign lowest = snap_ctrl.seen & (~snap_ctrl.seen + TAG_COUNT'(1));
  assign ok     = (calc == recv);
  assign ferr   = snap_ctrl.overflow || (snap_len < CNT_W'(TAIL_LEN));
  assign acc    = ok && !ferr && (|(lowest & type_enable_mask));

  assign slot_busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_enable_mask <= '1;
    end else if (cfg_we) begin
      type_enable_mask <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_ctrl.fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ctrl.fire) begin
      checksum_ok     <= ok;
      sentence_type   <= type_code;
      accepted        <= acc;
      computed_sum    <= calc;
      received_sum    <= recv;
      sentence_length <= snap_len;
      format_error    <= ferr;
    end
  end

endmodule

// ===== hw/rtl/nmea_sentence_checker.sv =====
// Top level of the NMEA sentence checker.
//
// Input channel: data_valid / data_stall / data_byte, one received character
// per word. Output channel: result_valid / result_stall plus the result
// fields; one result word is produced for each line feed, none otherwise.
// cfg_we / cfg_wdata write type_enable_mask (bit i enables tag i in the order
// RMC VTG GGA GSA GSV GLL); write only while the block is idle.
// Throughput: one byte per cycle while data_stall is low. A byte is captured in
// the input register, where it updates the sentence state; a line feed's result
// is then registered in the output word register, which drives result_valid.
// The output word register is the only place a result waits: while it holds
// an unaccepted result and result_stall is high, ordinary bytes keep flowing,
// and only a following line feed raises data_stall until the slot frees.
// Reset (rst, synchronous) clears the sentence state and both valid flags
// and sets type_enable_mask to all ones.
module nmea_sentence_checker
  import nsc_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF,
  parameter int SUM_START = SUM_START_DEF,
  parameter int TAIL_LEN  = TAIL_LEN_DEF,
  parameter int HEX_POS   = HEX_POS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TAG_COUNT-1:0] cfg_wdata,
  input  logic                 data_valid,
  output logic                 data_stall,
  input  logic [7:0]           data_byte,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 checksum_ok,
  output logic [TYPE_W-1:0]    sentence_type,
  output logic                 accepted,
  output logic [7:0]           computed_sum,
  output logic [7:0]           received_sum,
  output logic [CNT_W-1:0]     sentence_length,
  output logic                 format_error
);

  snap_ctrl_t               snap_ctrl;
  logic [CNT_W-1:0]         snap_len;
  logic [7:0]               snap_xor;
  logic [TAIL_LEN-1:0][7:0] snap_tail;
  logic                     slot_busy;

  nsc_track #(
    .BUF_DEPTH(BUF_DEPTH),
    .SUM_START(SUM_START),
    .TAIL_LEN (TAIL_LEN)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data_byte (data_byte),
    .slot_busy (slot_busy),
    .snap_ctrl (snap_ctrl),
    .snap_len  (snap_len),
    .snap_xor  (snap_xor),
    .snap_tail (snap_tail)
  );

  nsc_result #(
    .SUM_START(SUM_START),
    .TAIL_LEN (TAIL_LEN),
    .HEX_POS  (HEX_POS)
  ) u_result (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .snap_ctrl      (snap_ctrl),
    .snap_len       (snap_len),
    .snap_xor       (snap_xor),
    .snap_tail      (snap_tail),
    .slot_busy      (slot_busy),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .checksum_ok    (checksum_ok),
    .sentence_type  (sentence_type),
    .accepted       (accepted),
    .computed_sum   (computed_sum),
    .received_sum   (received_sum),
    .sentence_length(sentence_length),
    .format_error   (format_error)
  );

endmodule

// ===== tb/nmea_sentence_checker_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nmea_sentence_checker: directed and random byte streams, checked word by word.
module nmea_sentence_checker_tb;
  import nsc_pkg::*;

  localparam int BUF_DEPTH   = BUF_DEPTH_DEF;
  localparam int SUM_START   = SUM_START_DEF;
  localparam int TAIL_LEN    = TAIL_LEN_DEF;
  localparam int HEX_POS     = HEX_POS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 60;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic              checksum_ok;
    logic [TYPE_W-1:0] sentence_type;
    logic              accepted;
    byte_t             computed_sum;
    byte_t             received_sum;
    logic [CNT_W-1:0]  sentence_length;
    logic              format_error;
  } sentence_result_t;

  class sentence_tracker;
    logic [TAG_COUNT-1:0] enable_mask;
    logic [CNT_W-1:0]     count;
    byte_t                running_sum;
    byte_t                tail [TAIL_LEN];
    logic [23:0]          window;
    logic [TAG_COUNT-1:0] seen;
    logic                 overflow;
    sentence_result_t     pending [$];
    int                   mismatches;

    function new();
      enable_mask = '1;
      mismatches  = 0;
      start_sentence();
    endfunction

    function void start_sentence();
      count       = '0;
      running_sum = '0;
      foreach (tail[i]) tail[i] = '0;
      window      = '0;
      seen        = '0;
      overflow    = 1'b0;
    endfunction

    // Hex value of the character at sentence index idx, or -1.
    function int digit_at(int len, int idx);
      int    k;
      byte_t c;
      k = len - 1 - idx;
      if (idx < 0 || k < 0 || k >= TAIL_LEN) return -1;
      c = tail[k];
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    function void take_byte(byte_t b);
      int               len, idx, hi, lo;
      sentence_result_t r;
      if (int'(count) < BUF_DEPTH) begin
        if (int'(count) >= SUM_START) running_sum ^= b;
        for (int i = TAIL_LEN - 1; i > 0; i--) tail[i] = tail[i - 1];
        tail[0] = b;
        window  = {window[15:0], b};
        for (int i = 0; i < TAG_COUNT; i++) begin
          if (window == TAG_CODES[i]) seen[i] = 1'b1;
        end
        count++;
      end else begin
        overflow = 1'b1;
      end
      if (b != LINE_FEED) return;

      len = int'(count);
      r.computed_sum = running_sum;
      // checksum characters and line end are not part of the sum
      for (int k = 0; k < TAIL_LEN; k++) begin
        idx = len - 1 - k;
        if (idx >= 0 && idx >= len - HEX_POS && idx >= SUM_START) r.computed_sum ^= tail[k];
      end
      hi = digit_at(len, len - HEX_POS);
      lo = digit_at(len, len - HEX_POS + 1);
      if (hi < 0) begin
        r.received_sum = 8'd0;
      end else if (lo < 0) begin
        r.received_sum = byte_t'(hi);
      end else begin
        r.received_sum = byte_t'(hi * 16 + lo);
      end
      r.sentence_type = NO_TAG;
      for (int k = TAG_COUNT - 1; k >= 0; k--) begin
        if (seen[k]) r.sentence_type = TYPE_W'(k);
      end
      r.checksum_ok     = (r.computed_sum == r.received_sum);
      r.format_error    = overflow || (len < TAIL_LEN);
      r.accepted        = r.checksum_ok && !r.format_error && (r.sentence_type != NO_TAG) &&
                          enable_mask[r.sentence_type];
      r.sentence_length = CNT_W'(len);
      pending.push_back(r);
      start_sentence();
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_sentence(sentence_result_t got);
      sentence_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result word with no sentence pending");
        return;
      end
      want = pending.pop_front();
      if (got.checksum_ok !== want.checksum_ok)
        report_mismatch($sformatf("checksum_ok %0d, expected %0d",
                                  got.checksum_ok, want.checksum_ok));
      if (got.sentence_type !== want.sentence_type)
        report_mismatch($sformatf("sentence_type %0d, expected %0d",
                                  got.sentence_type, want.sentence_type));
      if (got.accepted !== want.accepted)
        report_mismatch($sformatf("accepted %0d, expected %0d", got.accepted, want.accepted));
      if (got.computed_sum !== want.computed_sum)
        report_mismatch($sformatf("computed_sum %0h, expected %0h",
                                  got.computed_sum, want.computed_sum));
      if (got.received_sum !== want.received_sum)
        report_mismatch($sformatf("received_sum %0h, expected %0h",
                                  got.received_sum, want.received_sum));
      if (got.sentence_length !== want.sentence_length)
        report_mismatch($sformatf("sentence_length %0d, expected %0d",
                                  got.sentence_length, want.sentence_length));
      if (got.format_error !== want.format_error)
        report_mismatch($sformatf("format_error %0d, expected %0d",
                                  got.format_error, want.format_error));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [TAG_COUNT-1:0] cfg_wdata;
  logic                 data_valid;
  logic                 data_stall;
  byte_t                data_byte;
  logic                 result_valid;
  logic                 result_stall;
  logic                 checksum_ok;
  logic [TYPE_W-1:0]    sentence_type;
  logic                 accepted;
  byte_t                computed_sum;
  byte_t                received_sum;
  logic [CNT_W-1:0]     sentence_length;
  logic                 format_error;

  bit              no_gaps;
  bit              hold_now;
  int              bytes_sent;
  sentence_tracker tracker = new();

  nmea_sentence_checker u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .data_valid      (data_valid),
    .data_stall      (data_stall),
    .data_byte       (data_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .checksum_ok     (checksum_ok),
    .sentence_type   (sentence_type),
    .accepted        (accepted),
    .computed_sum    (computed_sum),
    .received_sum    (received_sum),
    .sentence_length (sentence_length),
    .format_error    (format_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic byte_t hex_char(logic [3:0] nib, bit lower);
    if (nib < 4'd10) return 8'h30 + byte_t'(nib);
    return (lower ? 8'h61 : 8'h41) + byte_t'(nib) - 8'd10;
  endfunction

  // random sentence character, never a line feed
  function automatic byte_t body_char(bit any);
    byte_t c;
    c = any ? byte_t'($urandom_range(0, 255)) : byte_t'($urandom_range(8'h20, 8'h7E));
    if (c == LINE_FEED) c = 8'hF5;
    return c;
  endfunction

  task automatic send_byte(byte_t b);
    while (!no_gaps && $urandom_range(0, 99) < 37) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    do @(posedge clk); while (data_stall);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line(string text);
    for (int i = 0; i < text.len(); i++) send_byte(byte_t'(text[i]));
    send_byte(LINE_FEED);
  endtask

  // "$GP" + tag + body + "*hh" + CR LF; tag TAG_COUNT means no tag
  task automatic send_nmea(int tag, byte_t body[$], bit lower, bit corrupt);
    byte_t line[$];
    byte_t sum;
    line = {8'h24, 8'h47, 8'h50};
    if (tag < TAG_COUNT) begin
      for (int i = 2; i >= 0; i--) line.push_back(TAG_CODES[tag][8*i +: 8]);
    end
    foreach (body[i]) line.push_back(body[i]);
    line.push_back(8'h2A);
    sum = 8'h00;
    for (int i = SUM_START; i < line.size(); i++) sum ^= line[i];
    if (corrupt) sum ^= 8'h01 << $urandom_range(0, 7);
    line.push_back(hex_char(sum[7:4], lower));
    line.push_back(hex_char(sum[3:0], lower));
    line.push_back(8'h0D);
    line.push_back(LINE_FEED);
    foreach (line[i]) send_byte(line[i]);
  endtask

  task automatic random_phase(int count);
    int    stop, pick, tag2;
    byte_t body[$];
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      body = {};
      if (pick < 70) begin
        repeat ($urandom_range(0, 10)) body.push_back(body_char($urandom_range(0, 4) == 0));
        if ($urandom_range(0, 3) == 0) begin
          tag2 = $urandom_range(0, TAG_COUNT - 1);
          for (int i = 2; i >= 0; i--) body.push_back(TAG_CODES[tag2][8*i +: 8]);
        end
        send_nmea($urandom_range(0, TAG_COUNT), body, 1'($urandom_range(0, 1)),
                  $urandom_range(0, 9) == 0);
      end else begin
        repeat (pick < 85 ? $urandom_range(0, 8) : $urandom_range(0, 3))
          send_byte(pick < 85 ? byte_t'($urandom_range(0, 255)) : body_char(1'b0));
        send_byte(LINE_FEED);
      end
    end
  endtask

  task automatic reconfigure(logic [TAG_COUNT-1:0] mask);
    data_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.enable_mask = mask;
  endtask

  initial begin : receiver
    int               hold_left;
    sentence_result_t got;
    hold_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        got = {checksum_ok, sentence_type, accepted, computed_sum, received_sum,
               sentence_length, format_error};
        tracker.check_sentence(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_now) begin
        hold_now  = 1'b0;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !no_gaps && ($urandom_range(0, 99) < 37);
      end
    end
  end

  initial begin : stimulus
    byte_t body[$];
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    data_valid <= 1'b0;
    data_byte  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty line, zero and all-ones bytes, lowercase hex, no tag with bad sum,
    // second checksum char not hex, tag split across two lines
    send_line("");
    body = {8'h00, 8'hFF};
    send_nmea(0, body, 1'b1, 1'b0);
    body = {};
    send_nmea(TAG_COUNT, body, 1'b0, 1'b1);
    send_line("GLL*Ag\015");
    send_line("GG");
    send_line("A*00\015");

    reconfigure('0);
    random_phase(PHASE_BYTES);
    reconfigure('1);
    no_gaps = 1'b1;
    random_phase(PHASE_BYTES);
    no_gaps = 1'b0;
    reconfigure(TAG_COUNT'($urandom_range(0, 63)));
    hold_now = 1'b1;
    random_phase(PHASE_BYTES);

    // lines of 128 and 129 bytes at the buffer limit
    reconfigure(TAG_COUNT'(6'h01 << $urandom_range(0, 5)));
    for (int n = BUF_DEPTH - 11; n <= BUF_DEPTH - 10; n++) begin
      body = {};
      repeat (n) body.push_back(body_char(1'($urandom_range(0, 1))));
      send_nmea($urandom_range(0, TAG_COUNT - 1), body, 1'($urandom_range(0, 1)), 1'b0);
    end

    reconfigure(TAG_COUNT'($urandom_range(0, 63)));
    random_phase(PHASE_BYTES);

    data_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== nmea_sentence_checker.f =====
hw/rtl/nsc_pkg.sv
hw/rtl/nsc_track.sv
hw/rtl/nsc_result.sv
hw/rtl/nmea_sentence_checker.sv
tb/nmea_sentence_checker_tb.sv
